/* rtl/core/sld_pkg.sv */
// Shared types and constants for the sorted list difference block.
package sld_pkg;

    localparam int DATA_W = 32;

    // Request kinds carried on s_tuser
    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_RUN    = 2'd2
    } opcode_t;

    // Per-cycle commands broadcast to every list cell
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic shift_a;
        logic shift_b;
    } cell_ctrl_t;

endpackage

/* rtl/core/sld_cell.sv */
// One list cell: holds one slot of list A and one of list B, shifts toward the head.
module sld_cell #(
    parameter int CNT_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  logic                      aclk,
    input  sld_pkg::cell_ctrl_t       ctrl_i,
    input  logic [CNT_W-1:0]          wr_idx_i,
    input  logic [sld_pkg::DATA_W-1:0] elem_i,
    input  logic [sld_pkg::DATA_W-1:0] a_nbr_i,
    input  logic [sld_pkg::DATA_W-1:0] b_nbr_i,
    output logic [sld_pkg::DATA_W-1:0] a_o,
    output logic [sld_pkg::DATA_W-1:0] b_o
);
    import sld_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CELL_IDX[CNT_W-1:0];

    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] b_reg;
    logic [DATA_W-1:0] a_next;
    logic [DATA_W-1:0] b_next;
    logic              hit;

    assign hit = (wr_idx_i == MY_IDX);

    // Append writes the slot at the fill count; a shift takes the neighbor's slot
    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        if (ctrl_i.load_a && hit) begin
            a_next = elem_i;
        end else if (ctrl_i.shift_a) begin
            a_next = a_nbr_i;
        end
        if (ctrl_i.load_b && hit) begin
            b_next = elem_i;
        end else if (ctrl_i.shift_b) begin
            b_next = b_nbr_i;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign a_o = a_reg;
    assign b_o = b_reg;

endmodule

/* rtl/core/sorted_list_difference.sv */
// Top level: load/merge controller over a chain of list cells.
//
//  Channel | Ports                  | Payload
//  --------+------------------------+-------------------------------------------
//  request | s_tvalid/s_tready      | s_tuser: opcode; s_tdata: element
//  result  | m_tvalid/m_tready      | m_tdata: member; m_tlast: is_last;
//          |                        | m_tuser: empty_result, dropped_loads
//
// A load is taken whenever the block is idle. A run walks both lists in merge steps
// (at most the sum of both fill counts) and then closes; while both lists hold elements,
// each step compares the two head cells.
// A result stalled on m_tready holds the merge; no request is taken during a run.
// aresetn clears the fill counts, the overflow flag and all handshake state;
// list contents are left as they are and are only read below the fill count.
module sorted_list_difference #(
    parameter int LIST_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] element
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] member
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // [0] empty_result, [1] dropped_loads
);
    import sld_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = LIST_DEPTH[CNT_W-1:0];
    localparam logic [CNT_W-1:0] ONE_C   = {{(CNT_W-1){1'b0}}, 1'b1};

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  a_cnt_reg, a_cnt_next;
    logic [CNT_W-1:0]  b_cnt_reg, b_cnt_next;
    logic              ovf_reg, ovf_next;
    logic              pend_vld_reg, pend_vld_next;
    logic [DATA_W-1:0] pend_reg, pend_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;
    logic [1:0]        m_tuser_reg, m_tuser_next;

    cell_ctrl_t        ctrl;
    logic [CNT_W-1:0]  wr_idx;
    logic [DATA_W-1:0] a_q [LIST_DEPTH];
    logic [DATA_W-1:0] b_q [LIST_DEPTH];
    logic              accept;
    logic              out_free;
    logic              emit;
    opcode_t           op;

    // Cell chain; the tail cell refills from itself
    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] a_nbr;
        logic [DATA_W-1:0] b_nbr;
        if (i == LIST_DEPTH - 1) begin : g_tail
            assign a_nbr = a_q[i];
            assign b_nbr = b_q[i];
        end else begin : g_mid
            assign a_nbr = a_q[i+1];
            assign b_nbr = b_q[i+1];
        end
        sld_cell #(
            .CNT_W   (CNT_W),
            .CELL_IDX(i)
        ) u_cell (
            .aclk    (aclk),
            .ctrl_i  (ctrl),
            .wr_idx_i(wr_idx),
            .elem_i  (s_tdata),
            .a_nbr_i (a_nbr),
            .b_nbr_i (b_nbr),
            .a_o     (a_q[i]),
            .b_o     (b_q[i])
        );
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign op       = opcode_t'(s_tuser);

    // Load handling and one merge step per cycle while the output is free
    always_comb begin
        state_next    = state_reg;
        a_cnt_next    = a_cnt_reg;
        b_cnt_next    = b_cnt_reg;
        ovf_next      = ovf_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        ctrl          = '0;
        wr_idx        = a_cnt_reg;
        emit          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_LOAD_A: begin
                            if (a_cnt_reg < DEPTH_C) begin
                                ctrl.load_a = 1'b1;
                                a_cnt_next  = a_cnt_reg + ONE_C;
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_LOAD_B: begin
                            wr_idx = b_cnt_reg;
                            if (b_cnt_reg < DEPTH_C) begin
                                ctrl.load_b = 1'b1;
                                b_cnt_next  = b_cnt_reg + ONE_C;
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_RUN: begin
                            state_next    = ST_RUN;
                            pend_vld_next = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    if (a_cnt_reg != '0 && b_cnt_reg != '0) begin
                        if (a_q[0] == b_q[0]) begin
                            ctrl.shift_a = 1'b1;
                            ctrl.shift_b = 1'b1;
                            a_cnt_next   = a_cnt_reg - ONE_C;
                            b_cnt_next   = b_cnt_reg - ONE_C;
                        end else if ($signed(a_q[0]) > $signed(b_q[0])) begin
                            emit         = 1'b1;
                            ctrl.shift_b = 1'b1;
                            b_cnt_next   = b_cnt_reg - ONE_C;
                        end else begin
                            ctrl.shift_a = 1'b1;
                            a_cnt_next   = a_cnt_reg - ONE_C;
                        end
                    end else if (b_cnt_reg != '0) begin
                        emit         = 1'b1;
                        ctrl.shift_b = 1'b1;
                        b_cnt_next   = b_cnt_reg - ONE_C;
                    end else begin
                        // Close the run: flush the held member as last, or report empty
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = pend_vld_reg ? pend_reg : '0;
                        m_tlast_next  = 1'b1;
                        m_tuser_next  = {ovf_reg, !pend_vld_reg};
                        pend_vld_next = 1'b0;
                        a_cnt_next    = '0;
                        ovf_next      = 1'b0;
                        state_next    = ST_IDLE;
                    end

                    // One member is held back so the final one can carry tlast
                    if (emit) begin
                        if (pend_vld_reg) begin
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = pend_reg;
                            m_tlast_next  = 1'b0;
                            m_tuser_next  = {ovf_reg, 1'b0};
                        end
                        pend_next     = b_q[0];
                        pend_vld_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            a_cnt_reg    <= '0;
            b_cnt_reg    <= '0;
            ovf_reg      <= 1'b0;
            pend_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            a_cnt_reg    <= a_cnt_next;
            b_cnt_reg    <= b_cnt_next;
            ovf_reg      <= ovf_next;
            pend_vld_reg <= pend_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        pend_reg    <= pend_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* tb/sorted_list_difference_tb.sv */
// Self-checking testbench for the sorted list difference block.
`timescale 1ns / 100ps

module sorted_list_difference_tb;
    import sld_pkg::*;

    localparam int LIST_DEPTH = 64;
    localparam int CLK_PERIOD = 20;
    localparam int RANDOM_ITEMS = 360;
    localparam int PHASE_ITEMS = RANDOM_ITEMS / 4;
    // a run walks at most both lists and then closes
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 20;

    // opcode value outside the package enum; the block ignores it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic signed [31:0] ELEM_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] ELEM_MAX = 32'sh7FFF_FFFF;

    // one result item of a run
    typedef struct packed {
        logic signed [31:0] member;
        logic               last;
        logic               empty;
        logic               dropped;
    } diff_item_t;

    // one row of directed stimulus; typed rows carry a single known result
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] elem;
        logic        typed;
        diff_item_t  result;
    } request_row_t;

    localparam diff_item_t NO_ITEM    = '0;
    localparam diff_item_t EMPTY_ITEM = '{member: 32'sd0, last: 1'b1, empty: 1'b1,
                                          dropped: 1'b0};

    localparam request_row_t DIRECTED [25] = '{
        '{OP_RUN,    32'd0,        1'b1, EMPTY_ITEM},   // run right after reset
        '{OP_LOAD_B, ELEM_MIN,     1'b0, NO_ITEM},
        '{OP_RUN,    32'd0,        1'b1, '{ELEM_MIN, 1'b1, 1'b0, 1'b0}}, // A empty
        '{OP_LOAD_A, ELEM_MIN,     1'b0, NO_ITEM},
        '{OP_LOAD_A, 32'hFFFF_FFFF, 1'b0, NO_ITEM},
        '{OP_LOAD_A, 32'd5,        1'b0, NO_ITEM},
        '{OP_LOAD_B, ELEM_MIN,     1'b0, NO_ITEM},
        '{OP_LOAD_B, 32'd0,        1'b0, NO_ITEM},
        '{OP_LOAD_B, 32'd5,        1'b0, NO_ITEM},
        '{OP_LOAD_B, ELEM_MAX,     1'b0, NO_ITEM},
        '{OP_RUN,    ELEM_MAX,     1'b0, NO_ITEM},
        '{OP_LOAD_A, 32'd3,        1'b0, NO_ITEM},      // duplicates left over in A
        '{OP_LOAD_A, 32'd3,        1'b0, NO_ITEM},
        '{OP_LOAD_B, 32'd3,        1'b0, NO_ITEM},
        '{OP_RUN,    32'd0,        1'b1, EMPTY_ITEM},
        '{OP_LOAD_B, 32'd7,        1'b0, NO_ITEM},      // duplicates left over in B
        '{OP_LOAD_B, 32'd7,        1'b0, NO_ITEM},
        '{OP_LOAD_A, 32'd7,        1'b0, NO_ITEM},
        '{OP_RUN,    32'd0,        1'b0, NO_ITEM},
        '{OP_UNUSED, 32'hFFFF_FFFF, 1'b0, NO_ITEM},     // ignored opcode
        '{OP_RUN,    32'd0,        1'b1, EMPTY_ITEM},
        '{OP_LOAD_B, 32'd9,        1'b0, NO_ITEM},      // unsorted B
        '{OP_LOAD_B, 32'd1,        1'b0, NO_ITEM},
        '{OP_LOAD_A, 32'd1,        1'b0, NO_ITEM},
        '{OP_RUN,    32'd0,        1'b0, NO_ITEM}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] element
    logic [1:0]  s_tuser  = '0;   // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] member
    logic        m_tlast;
    logic [1:0]  m_tuser;         // [0] empty_result, [1] dropped_loads

    // predictor state
    logic signed [31:0] list_a [LIST_DEPTH];
    logic signed [31:0] list_b [LIST_DEPTH];
    int                 count_a;
    int                 count_b;
    logic               loads_dropped;
    diff_item_t         run_members [$];
    diff_item_t         pending_members [$];

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int issued_items  = 0;
    int runs_done     = 0;
    int overflow_runs = 0;
    int members_seen  = 0;
    int fail_count    = 0;

    sorted_list_difference #(
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // predictor: applies one request, leaves the results of a run in run_members
    function automatic void apply_request(input logic [1:0] op, input logic [31:0] elem);
        int ia;
        int ib;
        diff_item_t item;
        run_members.delete();
        ia = 0;
        ib = 0;
        case (op)
            OP_LOAD_A: begin
                if (count_a < LIST_DEPTH) begin
                    list_a[count_a] = elem;
                    count_a++;
                end else begin
                    loads_dropped = 1'b1;
                end
            end
            OP_LOAD_B: begin
                if (count_b < LIST_DEPTH) begin
                    list_b[count_b] = elem;
                    count_b++;
                end else begin
                    loads_dropped = 1'b1;
                end
            end
            OP_RUN: begin
                item = '{member: 32'sd0, last: 1'b0, empty: 1'b0, dropped: loads_dropped};
                // merge walk: equal heads cancel, smaller B head survives
                while (ia < count_a && ib < count_b) begin
                    if (list_a[ia] == list_b[ib]) begin
                        ia++;
                        ib++;
                    end else if (list_a[ia] > list_b[ib]) begin
                        item.member = list_b[ib];
                        run_members = {run_members, item};
                        ib++;
                    end else begin
                        ia++;
                    end
                end
                while (ib < count_b) begin
                    item.member = list_b[ib];
                    run_members = {run_members, item};
                    ib++;
                end
                if (run_members.size() == 0) begin
                    item.member = 32'sd0;
                    item.empty = 1'b1;
                    run_members = {run_members, item};
                end
                run_members[run_members.size() - 1].last = 1'b1;
                count_a = 0;
                count_b = 0;
                loads_dropped = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // drive one request, wait for its handshake, then record what it owes
    task automatic send_request(input request_row_t row);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.op;
        s_tdata  <= row.elem;
        do @(posedge aclk); while (!s_tready);
        if (row.op == OP_RUN) begin
            runs_done++;
            if (loads_dropped) overflow_runs++;
        end
        if (row.op != OP_UNUSED) issued_items++;
        apply_request(row.op, row.elem);
        if (row.typed) begin
            pending_members = {pending_members, row.result};
        end else begin
            foreach (run_members[k]) pending_members = {pending_members, run_members[k]};
        end
    endtask

    // load two lists with overlapping values, sorted unless scrambled, then run
    task automatic load_and_run(input bit force_overflow);
        int n_a;
        int n_b;
        int left_a;
        int left_b;
        logic signed [31:0] base;
        logic signed [31:0] a_val;
        logic signed [31:0] b_val;
        bit scrambled;
        request_row_t row;
        n_a = $urandom_range(0, 8);
        n_b = $urandom_range(0, 8);
        if (force_overflow) begin
            n_b = $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 3);
        end else if ($urandom_range(11) == 0) begin
            if ($urandom_range(1)) n_a = $urandom_range(LIST_DEPTH - 4, LIST_DEPTH + 2);
            else n_b = $urandom_range(LIST_DEPTH - 4, LIST_DEPTH + 2);
        end
        // a few batches ignore the sort order
        scrambled = ($urandom_range(7) == 0);
        case ($urandom_range(3))
            0: base = ELEM_MIN;
            1: base = ELEM_MAX - 2 * (n_a + n_b) - 3;
            default: base = $urandom;
        endcase
        a_val = base + $urandom_range(3);
        b_val = base + $urandom_range(3);
        left_a = n_a;
        left_b = n_b;
        row.typed = 1'b0;
        row.result = NO_ITEM;
        while (left_a + left_b > 0) begin
            if ($urandom_range(15) == 0) begin
                row.op = OP_UNUSED;
                row.elem = $urandom;
                send_request(row);
            end
            if (left_b == 0 || (left_a != 0 && $urandom_range(1))) begin
                row.op = OP_LOAD_A;
                row.elem = scrambled ? $urandom : a_val;
                a_val = a_val + $urandom_range(2);
                left_a--;
            end else begin
                row.op = OP_LOAD_B;
                row.elem = scrambled ? $urandom : b_val;
                b_val = b_val + $urandom_range(2);
                left_b--;
            end
            send_request(row);
        end
        row.op = OP_RUN;
        row.elem = $urandom;
        send_request(row);
    endtask

    // result checker
    always @(posedge aclk) begin
        diff_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            members_seen++;
            if (pending_members.size() == 0) begin
                $error("unexpected result: member %0d last %0b tuser %b",
                       $signed(m_tdata), m_tlast, m_tuser);
                fail_count++;
            end else begin
                want = pending_members.pop_front();
                if ($signed(m_tdata) != want.member) begin
                    $error("member: expected %0d, got %0d", want.member, $signed(m_tdata));
                    fail_count++;
                end
                if (m_tlast != want.last) begin
                    $error("is_last: expected %0b, got %0b", want.last, m_tlast);
                    fail_count++;
                end
                if (m_tuser[0] != want.empty) begin
                    $error("empty_result: expected %0b, got %0b", want.empty, m_tuser[0]);
                    fail_count++;
                end
                if (m_tuser[1] != want.dropped) begin
                    $error("dropped_loads: expected %0b, got %0b", want.dropped, m_tuser[1]);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        #(5_000_000);
        $display("** sorted_list_difference: FAILED **");
        $finish;
    end

    // main sequence
    initial begin
        int random_start;
        count_a = 0;
        count_b = 0;
        loads_dropped = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table, no idling
        foreach (DIRECTED[i]) send_request(DIRECTED[i]);

        // random part, one idling pattern per quarter
        random_start = issued_items;
        load_and_run(1'b1);
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 48; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 48; end
                default: begin src_idle_pct = 10; sink_stall_pct = 10; end
            endcase
            while (issued_items < random_start + (phase + 1) * PHASE_ITEMS) begin
                load_and_run(1'b0);
            end
        end
        s_tvalid <= 1'b0;

        // drain, then watch for stray results
        while (pending_members.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests in %0d runs, %0d of them after dropped loads.",
                 issued_items, runs_done, overflow_runs);
        $display("Checked %0d result items under four idle/stall patterns.", members_seen);
        if (fail_count == 0) begin
            $display("** sorted_list_difference: PASSED **");
        end else begin
            $display("** sorted_list_difference: FAILED **");
        end
        $finish;
    end

endmodule
